// File: sv/ksrd_pkg.sv
package ksrd_pkg;

    localparam int CountWidth = 16;
    localparam int KeyWidth   = 2;
    localparam int KeyCount   = 3;
    localparam int CfgIdxWidth = 2;

    localparam logic [CountWidth-1:0] COUNT_MAX       = 16'hFFFF;
    localparam logic [CountWidth-1:0] RESET_THRESHOLD = 16'd100;
    localparam logic [CountWidth-1:0] RESET_PERIOD    = 16'd10;

    localparam logic [KeyWidth-1:0] KEY_NONE    = 2'd0;
    localparam logic [KeyWidth-1:0] BTN_CONFIRM = 2'd1;
    localparam logic [KeyWidth-1:0] BTN_NEXT    = 2'd2;
    localparam logic [KeyWidth-1:0] BTN_LAST    = 2'd3;

    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_NOTIFY = 1'b1;

    localparam logic [CfgIdxWidth-1:0] REG_LONG_THRESHOLD = 2'd0;
    localparam logic [CfgIdxWidth-1:0] REG_REPEAT_PERIOD  = 2'd1;

    typedef struct packed {
        logic [CountWidth-1:0] long_threshold;
        logic [CountWidth-1:0] repeat_period;
    } cfg_t;

    typedef struct packed {
        logic                valid;
        logic [KeyWidth-1:0] key;
        logic                is_long;
    } result_t;

    // lowest set bit wins: confirm, then next, then last
    function automatic logic [KeyWidth-1:0] pick_key(input logic [KeyCount-1:0] mask);
        logic [KeyWidth-1:0] k;
        begin
            k = KEY_NONE;
            if (mask[0])
                k = BTN_CONFIRM;
            else if (mask[1])
                k = BTN_NEXT;
            else if (mask[2])
                k = BTN_LAST;
            return k;
        end
    endfunction

    function automatic logic key_level(input logic [KeyCount-1:0] levels,
                                       input logic [KeyWidth-1:0] key);
        logic lv;
        begin
            case (key)
                BTN_CONFIRM: lv = levels[0];
                BTN_NEXT:    lv = levels[1];
                BTN_LAST:    lv = levels[2];
                default:     lv = 1'b0;
            endcase
            return lv;
        end
    endfunction

endpackage

// File: sv/ksrd_cfg.sv
module ksrd_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [ksrd_pkg::CfgIdxWidth-1:0]  cfg_index,
    input  logic [ksrd_pkg::CountWidth-1:0]   cfg_data,
    output ksrd_pkg::cfg_t                    cfg
);

    logic [ksrd_pkg::CountWidth-1:0] threshold_reg;
    logic [ksrd_pkg::CountWidth-1:0] period_reg;

    // unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= ksrd_pkg::RESET_THRESHOLD;
            period_reg    <= ksrd_pkg::RESET_PERIOD;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ksrd_pkg::REG_LONG_THRESHOLD: threshold_reg <= cfg_data;
                ksrd_pkg::REG_REPEAT_PERIOD:  period_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.long_threshold = threshold_reg;
    assign cfg.repeat_period  = period_reg;

endmodule

// File: sv/ksrd_core.sv
module ksrd_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ksrd_pkg::cfg_t                   cfg,
    input  logic                             accept,
    input  logic                             kind,
    input  logic [ksrd_pkg::KeyCount-1:0]    notify_mask,
    input  logic [ksrd_pkg::KeyCount-1:0]    pressed_levels,
    output ksrd_pkg::result_t                result
);

    logic [ksrd_pkg::KeyWidth-1:0]   active_key_reg, active_key_next;
    logic [ksrd_pkg::CountWidth-1:0] hold_count_reg, hold_count_next;
    logic [ksrd_pkg::CountWidth-1:0] repeat_phase_reg, repeat_phase_next;
    logic                            long_sent_reg, long_sent_next;

    logic [ksrd_pkg::KeyWidth-1:0]   sel_key;
    logic [ksrd_pkg::CountWidth:0]   phase_inc;
    logic [ksrd_pkg::CountWidth-1:0] count_step;
    logic [ksrd_pkg::CountWidth-1:0] phase_step;

    assign sel_key    = ksrd_pkg::pick_key(notify_mask);
    assign count_step = hold_count_reg + 1'b1;
    assign phase_inc  = {1'b0, repeat_phase_reg} + 1'b1;

    always_comb
    begin
        if (count_step == cfg.long_threshold)
            phase_step = '0;
        else if (count_step > cfg.long_threshold)
            phase_step = (phase_inc >= {1'b0, cfg.repeat_period}) ? '0
                         : phase_inc[ksrd_pkg::CountWidth-1:0];
        else
            phase_step = repeat_phase_reg;
    end

    always_comb
    begin
        active_key_next   = active_key_reg;
        hold_count_next   = hold_count_reg;
        repeat_phase_next = repeat_phase_reg;
        long_sent_next    = long_sent_reg;
        result            = '0;
        if (accept)
        begin
            if (kind == ksrd_pkg::KIND_NOTIFY)
            begin
                if (sel_key != ksrd_pkg::KEY_NONE &&
                    ksrd_pkg::key_level(pressed_levels, sel_key) &&
                    active_key_reg == ksrd_pkg::KEY_NONE)
                begin
                    active_key_next   = sel_key;
                    hold_count_next   = '0;
                    repeat_phase_next = '0;
                    long_sent_next    = 1'b0;
                end
            end
            else if (active_key_reg != ksrd_pkg::KEY_NONE)
            begin
                if (ksrd_pkg::key_level(pressed_levels, active_key_reg))
                begin
                    // phase freezes once the count is saturated
                    if (hold_count_reg != ksrd_pkg::COUNT_MAX)
                    begin
                        hold_count_next   = count_step;
                        repeat_phase_next = phase_step;
                    end
                    if (hold_count_next >= cfg.long_threshold && repeat_phase_next == '0)
                    begin
                        long_sent_next = 1'b1;
                        result.valid   = 1'b1;
                        result.key     = active_key_reg;
                        result.is_long = 1'b1;
                    end
                end
                else
                begin
                    active_key_next   = ksrd_pkg::KEY_NONE;
                    hold_count_next   = '0;
                    repeat_phase_next = '0;
                    long_sent_next    = 1'b0;
                    result.valid      = !long_sent_reg;
                    result.key        = active_key_reg;
                    result.is_long    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_key_reg   <= ksrd_pkg::KEY_NONE;
            hold_count_reg   <= '0;
            repeat_phase_reg <= '0;
            long_sent_reg    <= 1'b0;
        end
        else
        begin
            active_key_reg   <= active_key_next;
            hold_count_reg   <= hold_count_next;
            repeat_phase_reg <= repeat_phase_next;
            long_sent_reg    <= long_sent_next;
        end
    end

`ifndef SYNTH
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        active_key_reg == ksrd_pkg::KEY_NONE |->
            hold_count_reg == '0 && repeat_phase_reg == '0 && !long_sent_reg)
        else $error("idle with stale hold state");

    a_long_marks: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.is_long |=> long_sent_reg)
        else $error("long event without long_sent");

    a_short_idles: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.is_long |=> active_key_reg == ksrd_pkg::KEY_NONE)
        else $error("short event did not release key");
`endif

endmodule

// File: sv/ksrd_out_buf.sv
module ksrd_out_buf (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ksrd_pkg::result_t              push,
    output logic                           room,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ksrd_pkg::KeyWidth-1:0]  event_key,
    output logic                           event_long
);

    logic                          main_valid_reg;
    logic [ksrd_pkg::KeyWidth-1:0] main_key_reg;
    logic                          main_long_reg;
    logic                          skid_valid_reg;
    logic [ksrd_pkg::KeyWidth-1:0] skid_key_reg;
    logic                          skid_long_reg;
    logic                          pop;

    assign pop  = main_valid_reg && out_ready;
    // a push only happens while the skid slot is free
    assign room = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                main_valid_reg <= push.valid;
        end
        else if (push.valid)
        begin
            if (main_valid_reg)
                skid_valid_reg <= 1'b1;
            else
                main_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            main_key_reg  <= skid_key_reg;
            main_long_reg <= skid_long_reg;
        end
        else if (push.valid && (pop || !main_valid_reg))
        begin
            main_key_reg  <= push.key;
            main_long_reg <= push.is_long;
        end
        if (push.valid && main_valid_reg && !pop)
        begin
            skid_key_reg  <= push.key;
            skid_long_reg <= push.is_long;
        end
    end

    assign out_valid  = main_valid_reg;
    assign event_key  = main_key_reg;
    assign event_long = main_long_reg;

endmodule

// File: sv/key_short_long_repeat_detector.sv
// Channel | Handshake            | Word
// --------+----------------------+------------------------------------------
// in      | in_valid / in_ready  | kind, notify_mask, pressed_levels
// out     | out_valid / out_ready| event_key, event_long
// cfg     | cfg_valid / cfg_ready| cfg_index (0 threshold, 1 period), cfg_data
//
// One input word per cycle while in_ready is high; the hold state updates at the
// accepting edge and a result is registered into a two-slot output buffer.
// in_ready drops only while both buffer slots hold results (out stalled).
// cfg_ready is always high; writes land at the edge they are accepted.
// Reset (rst_n low, async) clears the key state and loads threshold 100 and
// period 10; no clearing pass is needed.
module key_short_long_repeat_detector (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              kind,
    input  logic [ksrd_pkg::KeyCount-1:0]     notify_mask,
    input  logic [ksrd_pkg::KeyCount-1:0]     pressed_levels,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ksrd_pkg::KeyWidth-1:0]     event_key,
    output logic                              event_long,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ksrd_pkg::CfgIdxWidth-1:0]  cfg_index,
    input  logic [ksrd_pkg::CountWidth-1:0]   cfg_data
);

    ksrd_pkg::cfg_t    cfg;
    ksrd_pkg::result_t result;
    logic              room;
    logic              accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = room;
    assign accept    = in_valid && room;

    // threshold and period registers
    ksrd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // key tracking: active key, hold count, repeat phase, long flag
    ksrd_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .accept         (accept),
        .kind           (kind),
        .notify_mask    (notify_mask),
        .pressed_levels (pressed_levels),
        .result         (result)
    );

    // result register plus skid slot so one more result can be taken under a stall
    ksrd_out_buf u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (result),
        .room       (room),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_key  (event_key),
        .event_long (event_long)
    );

endmodule
